[design/bts_pkg.sv]
// Shared types, widths, register codes and reset values of the tone sequencer.
package bts_pkg;

    localparam int MAX_STEPS    = 8;
    localparam int NUM_PATTERNS = 5;

    typedef logic [7:0]  tick_t;
    typedef logic [15:0] period_t;
    typedef logic [14:0] high_time_t;
    typedef logic [19:0] pattern_t;
    typedef logic [19:0] cfg_data_t;
    typedef logic [2:0]  pattern_sel_t;
    typedef logic [3:0]  step_idx_t;
    typedef logic [1:0]  step_val_t;

    typedef enum logic [2:0] {
        REG_TICK_DIVIDE   = 3'd0,
        REG_BASE_PERIOD   = 3'd1,
        REG_STEP_SCALE    = 3'd2,
        REG_PATTERN_ZERO  = 3'd3,
        REG_PATTERN_ONE   = 3'd4,
        REG_PATTERN_TWO   = 3'd5,
        REG_PATTERN_THREE = 3'd6,
        REG_PATTERN_FOUR  = 3'd7
    } cfg_index_t;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_START = 1'b1
    } op_t;

    localparam tick_t    TICK_DIVIDE_RESET   = 8'd100;
    localparam period_t  BASE_PERIOD_RESET   = 16'h03FF;
    localparam period_t  STEP_SCALE_RESET    = 16'd200;
    localparam pattern_t PATTERN_ZERO_RESET  = 20'd435;
    localparam pattern_t PATTERN_ONE_RESET   = 20'd4373;
    localparam pattern_t PATTERN_TWO_RESET   = 20'd69975;
    localparam pattern_t PATTERN_THREE_RESET = 20'd275;
    localparam pattern_t PATTERN_FOUR_RESET  = 20'd145;

endpackage

[design/bts_if.sv]
// Handshake channel interfaces for commands, results and register writes.
interface bts_cmd_if;
    import bts_pkg::*;
    logic         valid;
    logic         ready;
    op_t          op;
    pattern_sel_t pattern_sel;

    modport source (output valid, output op, output pattern_sel, input ready);
    modport sink   (input valid, input op, input pattern_sel, output ready);
endinterface

interface bts_res_if;
    import bts_pkg::*;
    logic       valid;
    logic       ready;
    period_t    pwm_period;
    high_time_t pwm_high_time;
    logic       pwm_running;
    logic       step_loaded;
    logic       finished;

    modport source (output valid, output pwm_period, output pwm_high_time,
                    output pwm_running, output step_loaded, output finished,
                    input ready);
    modport sink   (input valid, input pwm_period, input pwm_high_time,
                    input pwm_running, input step_loaded, input finished,
                    output ready);
endinterface

interface bts_cfg_if;
    import bts_pkg::*;
    logic       valid;
    logic       ready;
    cfg_index_t index;
    cfg_data_t  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[design/beep_tone_sequencer_unit.sv]
// Buzzer tone sequencer: five stored patterns played as PWM period and high time.
//
// The block plays one of five stored tone patterns on a buzzer PWM. A start
// beat on cmd selects a pattern and loads its first tone step straight away;
// each tick beat then advances a counter, and after tick_divide ticks the next
// step is loaded. Every command beat yields exactly one result beat on res,
// which shows the PWM period and high time after that command, whether the
// PWM is running, whether a step was loaded and whether the pattern ended.
// A beat accepted at a clock edge is held in the command register, its
// effect on the step state is worked out combinationally from there, and
// its result is presented from the result register. One beat per cycle is
// sustained while res takes each result: the step state update is a single
// short pass (a 16 by 2 bit multiply-add with saturation) between the
// command register and the result register. A full result register that is
// not being taken stalls the command register, and cmd.ready drops only then.
// Register writes on cfg are always taken in the cycle they are offered and
// must only be made while no command is in flight.
module beep_tone_sequencer_unit
(
    input  logic             clk,
    input  logic             rst_n,
    bts_cmd_if.sink          cmd,
    bts_res_if.source        res,
    bts_cfg_if.sink          cfg
);
    import bts_pkg::*;

    // Configuration registers
    tick_t    tick_divide_reg;
    period_t  base_period_reg;
    period_t  step_scale_reg;
    pattern_t pattern_zero_reg;
    pattern_t pattern_one_reg;
    pattern_t pattern_two_reg;
    pattern_t pattern_three_reg;
    pattern_t pattern_four_reg;

    // Sequencer state
    logic         active_reg,          active_next;
    step_idx_t    step_index_reg,      step_index_next;
    tick_t        tick_count_reg,      tick_count_next;
    pattern_sel_t current_pattern_reg, current_pattern_next;
    period_t      period_reg,          period_next;
    high_time_t   high_time_reg,       high_time_next;

    // Command register and result register
    logic         cmd_valid_reg;
    op_t          cmd_op_reg;
    pattern_sel_t cmd_sel_reg;
    logic         res_valid_reg;
    period_t      res_period_reg;
    high_time_t   res_high_time_reg;
    logic         res_running_reg;
    logic         res_loaded_reg;
    logic         res_finished_reg;

    logic         advance;
    logic         loaded_next;
    logic         finished_next;

    // Step computation
    pattern_t     word_sel;
    pattern_t     word_cur;
    pattern_t     step_word;
    logic [2:0]   step_pos;
    logic [4:0]   step_shamt;
    step_val_t    step_val;
    logic [17:0]  step_product;
    logic [17:0]  step_sum;
    period_t      step_period;
    tick_t        tick_inc;

    function automatic pattern_t pick_pattern(input pattern_sel_t sel,
                                              input pattern_t w0, input pattern_t w1,
                                              input pattern_t w2, input pattern_t w3,
                                              input pattern_t w4);
        pattern_t w;
        unique case (sel)
            3'd0:    w = w0;
            3'd1:    w = w1;
            3'd2:    w = w2;
            3'd3:    w = w3;
            3'd4:    w = w4;
            3'd5:    w = w0;
            3'd6:    w = w1;
            default: w = w2;
        endcase
        return w;
    endfunction

    function automatic step_idx_t pattern_length(input pattern_t w);
        step_idx_t len;
        len = w[3:0];
        if (len > step_idx_t'(MAX_STEPS))
        begin
            len = step_idx_t'(MAX_STEPS);
        end
        return len;
    endfunction

    // Handshake: the command register moves on when the result register is
    // empty or is being emptied in this cycle.
    assign advance   = cmd_valid_reg && (!res_valid_reg || res.ready);
    assign cmd.ready = !cmd_valid_reg || advance;
    assign cfg.ready = 1'b1;

    assign res.valid         = res_valid_reg;
    assign res.pwm_period    = res_period_reg;
    assign res.pwm_high_time = res_high_time_reg;
    assign res.pwm_running   = res_running_reg;
    assign res.step_loaded   = res_loaded_reg;
    assign res.finished      = res_finished_reg;

    // A start reads step 0 of the selected pattern, a tick reads the step at
    // the current index of the pattern in play.
    assign word_sel = pick_pattern(cmd_sel_reg, pattern_zero_reg, pattern_one_reg,
                                   pattern_two_reg, pattern_three_reg, pattern_four_reg);
    assign word_cur = pick_pattern(current_pattern_reg, pattern_zero_reg,
                                   pattern_one_reg, pattern_two_reg,
                                   pattern_three_reg, pattern_four_reg);

    assign step_word    = (cmd_op_reg == OP_START) ? word_sel : word_cur;
    assign step_pos     = (cmd_op_reg == OP_START) ? 3'd0 : step_index_reg[2:0];
    assign step_shamt   = 5'd4 + {1'b0, step_pos, 1'b0};
    assign step_val     = step_word[step_shamt +: 2];
    assign step_product = 18'(step_scale_reg) * 18'(step_val);
    assign step_sum     = 18'(base_period_reg) + step_product;
    assign tick_inc     = tick_count_reg + 8'd1;

    // A silent step has period zero; otherwise the sum saturates at 16 bits.
    always_comb
    begin
        if (step_val == 2'd0)
        begin
            step_period = '0;
        end
        else if (step_sum[17:16] != 2'b00)
        begin
            step_period = '1;
        end
        else
        begin
            step_period = step_sum[15:0];
        end
    end

    always_comb
    begin
        active_next          = active_reg;
        step_index_next      = step_index_reg;
        tick_count_next      = tick_count_reg;
        current_pattern_next = current_pattern_reg;
        period_next          = period_reg;
        high_time_next       = high_time_reg;
        loaded_next          = 1'b0;
        finished_next        = 1'b0;

        if (cmd_op_reg == OP_START)
        begin
            // Selectors beyond the stored patterns are ignored.
            if (cmd_sel_reg < pattern_sel_t'(NUM_PATTERNS))
            begin
                current_pattern_next = cmd_sel_reg;
                tick_count_next      = '0;
                if (pattern_length(word_sel) == '0)
                begin
                    // An empty pattern leaves the PWM off and ends at once.
                    active_next     = 1'b0;
                    step_index_next = '0;
                    finished_next   = 1'b1;
                end
                else
                begin
                    period_next     = step_period;
                    high_time_next  = step_period[15:1];
                    step_index_next = step_idx_t'(1);
                    active_next     = 1'b1;
                    loaded_next     = 1'b1;
                end
            end
        end
        else if (active_reg)
        begin
            // A tick divide of zero lets the counter wrap: 256 ticks a step.
            if (tick_inc == tick_divide_reg)
            begin
                tick_count_next = '0;
                if (step_index_reg >= pattern_length(word_cur))
                begin
                    active_next   = 1'b0;
                    finished_next = 1'b1;
                end
                else
                begin
                    period_next     = step_period;
                    high_time_next  = step_period[15:1];
                    step_index_next = step_index_reg + step_idx_t'(1);
                    loaded_next     = 1'b1;
                end
            end
            else
            begin
                tick_count_next = tick_inc;
            end
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_divide_reg   <= TICK_DIVIDE_RESET;
            base_period_reg   <= BASE_PERIOD_RESET;
            step_scale_reg    <= STEP_SCALE_RESET;
            pattern_zero_reg  <= PATTERN_ZERO_RESET;
            pattern_one_reg   <= PATTERN_ONE_RESET;
            pattern_two_reg   <= PATTERN_TWO_RESET;
            pattern_three_reg <= PATTERN_THREE_RESET;
            pattern_four_reg  <= PATTERN_FOUR_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_TICK_DIVIDE:   tick_divide_reg   <= cfg.data[7:0];
                REG_BASE_PERIOD:   base_period_reg   <= cfg.data[15:0];
                REG_STEP_SCALE:    step_scale_reg    <= cfg.data[15:0];
                REG_PATTERN_ZERO:  pattern_zero_reg  <= cfg.data;
                REG_PATTERN_ONE:   pattern_one_reg   <= cfg.data;
                REG_PATTERN_TWO:   pattern_two_reg   <= cfg.data;
                REG_PATTERN_THREE: pattern_three_reg <= cfg.data;
                REG_PATTERN_FOUR:  pattern_four_reg  <= cfg.data;
                default:           tick_divide_reg   <= tick_divide_reg;
            endcase
        end
    end

    // Control state, including the sequencer state and the valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg       <= 1'b0;
            res_valid_reg       <= 1'b0;
            active_reg          <= 1'b0;
            step_index_reg      <= '0;
            tick_count_reg      <= '0;
            current_pattern_reg <= '0;
            period_reg          <= '0;
            high_time_reg       <= '0;
        end
        else
        begin
            if (cmd.ready)
            begin
                cmd_valid_reg <= cmd.valid;
            end
            if (advance)
            begin
                res_valid_reg       <= 1'b1;
                active_reg          <= active_next;
                step_index_reg      <= step_index_next;
                tick_count_reg      <= tick_count_next;
                current_pattern_reg <= current_pattern_next;
                period_reg          <= period_next;
                high_time_reg       <= high_time_next;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            cmd_op_reg  <= cmd.op;
            cmd_sel_reg <= cmd.pattern_sel;
        end
        if (advance)
        begin
            res_period_reg    <= period_next;
            res_high_time_reg <= high_time_next;
            res_running_reg   <= active_next;
            res_loaded_reg    <= loaded_next;
            res_finished_reg  <= finished_next;
        end
    end

`ifndef ASSERT_OFF
    // A result never both loads a step and ends the pattern.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> !(res_loaded_reg && res_finished_reg))
        else $error("result reports a loaded step and a finished pattern");

    // The end of a pattern always stops the PWM.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_finished_reg |-> !res_running_reg)
        else $error("finished pattern left the PWM running");

    // The reported high time is always half the reported period.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_high_time_reg == res_period_reg[15:1]))
        else $error("high time is not half the period");

    // While playing, at least one step has been loaded and no more than the maximum.
    assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (step_index_reg != '0) &&
                       (step_index_reg <= step_idx_t'(MAX_STEPS)))
        else $error("step index out of range while playing");
`endif

endmodule
